// ----- design/swsr_pkg.sv -----
// Shared types, constants and helpers for the single-wire sensor reader.
`default_nettype none

package swsr_pkg;

  // Width of the pulse timer; it saturates at its all-ones value
  localparam int COUNT_BITS = 16;
  localparam int FRAME_LEN  = 40;
  localparam int BIDX_BITS  = 6;

  typedef logic [COUNT_BITS-1:0] cnt_t;
  localparam cnt_t CNT_MAX = {COUNT_BITS{1'b1}};

  // APB register map, one 32-bit word per register
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_START_LOW = 2'd0;
  localparam reg_idx_t REG_RELEASE   = 2'd1;
  localparam reg_idx_t REG_TIMEOUT   = 2'd2;
  localparam reg_idx_t REG_ONE_THR   = 2'd3;

  localparam logic [15:0] START_LOW_RST = 16'd18000;
  localparam logic [9:0]  RELEASE_RST   = 10'd40;
  localparam logic [9:0]  TIMEOUT_RST   = 10'd100;
  localparam logic [9:0]  ONE_THR_RST   = 10'd40;

  // Status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_TIMEOUT  = 2'd1;
  localparam status_t ST_CHECKSUM = 2'd2;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [9:0]  release_ticks;
    logic [9:0]  timeout_ticks;
    logic [9:0]  one_threshold_ticks;
  } cfg_t;

  typedef enum logic [6:0] {
    PH_IDLE      = 7'b0000001,
    PH_START_LOW = 7'b0000010,
    PH_RELEASE   = 7'b0000100,
    PH_RESP_LOW  = 7'b0001000,
    PH_RESP_HIGH = 7'b0010000,
    PH_BIT_LOW   = 7'b0100000,
    PH_BIT_HIGH  = 7'b1000000
  } phase_t;

  // Saturating increment of the pulse timer
  function automatic cnt_t bump(input cnt_t c);
    return (c == CNT_MAX) ? c : cnt_t'(c + 1'b1);
  endfunction

endpackage

`default_nettype wire

// ----- design/swsr_regs.sv -----
// APB configuration registers of the single-wire sensor reader.
`default_nettype none

module swsr_regs
  import swsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_paddr[CFG_AW-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  // Write the addressed register, masked to its width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_ticks     <= START_LOW_RST;
      cfg_r.release_ticks       <= RELEASE_RST;
      cfg_r.timeout_ticks       <= TIMEOUT_RST;
      cfg_r.one_threshold_ticks <= ONE_THR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_START_LOW: cfg_r.start_low_ticks     <= cfg_pwdata[15:0];
        REG_RELEASE:   cfg_r.release_ticks       <= cfg_pwdata[9:0];
        REG_TIMEOUT:   cfg_r.timeout_ticks       <= cfg_pwdata[9:0];
        REG_ONE_THR:   cfg_r.one_threshold_ticks <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (idx)
      REG_START_LOW: cfg_prdata = CFG_DW'(cfg_r.start_low_ticks);
      REG_RELEASE:   cfg_prdata = CFG_DW'(cfg_r.release_ticks);
      REG_TIMEOUT:   cfg_prdata = CFG_DW'(cfg_r.timeout_ticks);
      REG_ONE_THR:   cfg_prdata = CFG_DW'(cfg_r.one_threshold_ticks);
      default:       cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/single_wire_sensor_reader.sv -----
// Latency: a result appears on out_tdata the cycle after its tick request is accepted.
// Throughput: one tick request per cycle; a request is taken in the same cycle the
// previous result leaves the output register, so the rate is set only by out_tready.
// Reset (rst_n, synchronous): idle phase, timer, bit count, frame, status and
// readings cleared; configuration registers return to their default values.
`default_nettype none

module single_wire_sensor_reader
  import swsr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // tick request channel
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [7:0]        in_tdata,  // [0] start_req, [1] line_level, [7:2] zero
  // result channel
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic      [23:0]       out_tdata, // [0] drive_enable, [1] drive_level,
                                            // [2] busy_res, [3] done_res, [5:4] status,
                                            // [13:6] temperature, [21:14] humidity,
                                            // [23:22] zero
  // configuration port
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [CFG_AW-1:0] cfg_paddr,
  input  wire logic [CFG_DW-1:0] cfg_pwdata,
  output logic      [CFG_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_t cfg;

  swsr_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  phase_t                 phase_r, phase_nxt;
  cnt_t                   tick_r, tick_nxt;
  logic [BIDX_BITS-1:0]   bidx_r, bidx_nxt;
  logic [FRAME_LEN-1:0]   frame_r, frame_nxt;
  status_t                status_r, status_nxt;
  logic [7:0]             temp_r, temp_nxt;
  logic [7:0]             hum_r, hum_nxt;
  logic                   out_valid_r;
  logic [23:0]            out_data_r, res_data;

  logic req, lvl, accept;
  logic drv_en, drv_lvl, done, fail, wait_lvl;
  logic [7:0] sum;

  assign req       = in_tdata[0];
  assign lvl       = in_tdata[1];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Advance the reader by one tick
  always_comb begin
    phase_nxt  = phase_r;
    tick_nxt   = tick_r;
    bidx_nxt   = bidx_r;
    frame_nxt  = frame_r;
    status_nxt = status_r;
    temp_nxt   = temp_r;
    hum_nxt    = hum_r;
    drv_en     = 1'b0;
    drv_lvl    = 1'b0;
    done       = 1'b0;
    fail       = 1'b0;
    wait_lvl   = 1'b0;
    sum        = '0;

    // start a reading on request
    if (phase_nxt == PH_IDLE && req) begin
      phase_nxt = PH_START_LOW;
      tick_nxt  = '0;
    end
    // hold the line low
    if (phase_nxt == PH_START_LOW) begin
      if (tick_nxt >= cfg.start_low_ticks || tick_nxt == CNT_MAX) begin
        phase_nxt = PH_RELEASE;
        tick_nxt  = '0;
      end else begin
        tick_nxt = bump(tick_nxt);
        drv_en   = 1'b1;
      end
    end
    // drive high before release
    if (phase_nxt == PH_RELEASE) begin
      if (tick_nxt >= cnt_t'(cfg.release_ticks)) begin
        phase_nxt = PH_RESP_LOW;
        tick_nxt  = '0;
      end else begin
        tick_nxt = bump(tick_nxt);
        drv_en   = 1'b1;
        drv_lvl  = 1'b1;
      end
    end

    // time the sensor's response and data pulses
    if (!drv_en && (phase_nxt == PH_RESP_LOW || phase_nxt == PH_RESP_HIGH ||
                    phase_nxt == PH_BIT_LOW || phase_nxt == PH_BIT_HIGH)) begin
      wait_lvl = (phase_nxt == PH_RESP_HIGH || phase_nxt == PH_BIT_HIGH);
      if (lvl == wait_lvl) begin
        tick_nxt = bump(tick_nxt);
      end else begin
        unique case (phase_nxt)
          PH_RESP_LOW:  phase_nxt = PH_RESP_HIGH;
          PH_RESP_HIGH: begin
            phase_nxt = PH_BIT_LOW;
            bidx_nxt  = '0;
            frame_nxt = '0;
          end
          PH_BIT_LOW:   phase_nxt = PH_BIT_HIGH;
          PH_BIT_HIGH:  begin
            frame_nxt = {frame_nxt[FRAME_LEN-2:0], tick_nxt > cnt_t'(cfg.one_threshold_ticks)};
            bidx_nxt  = bidx_nxt + 1'b1;
            phase_nxt = PH_BIT_LOW;
          end
          default: phase_nxt = PH_IDLE;
        endcase
        tick_nxt = cnt_t'(1);
      end

      // close the frame and check it
      if (phase_nxt == PH_BIT_LOW && bidx_nxt >= BIDX_BITS'(FRAME_LEN)) begin
        sum = frame_nxt[39:32] + frame_nxt[31:24] + frame_nxt[23:16] + frame_nxt[15:8];
        if (sum == frame_nxt[7:0]) begin
          status_nxt = ST_OK;
          hum_nxt    = frame_nxt[39:32];
          temp_nxt   = frame_nxt[23:16];
        end else begin
          status_nxt = ST_CHECKSUM;
        end
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
        done      = 1'b1;
      end else if (tick_nxt > cnt_t'(cfg.timeout_ticks)) begin
        fail = 1'b1;
      end
      // abort on an overlong phase
      if (fail) begin
        status_nxt = ST_TIMEOUT;
        phase_nxt  = PH_IDLE;
        tick_nxt   = '0;
        done       = 1'b1;
      end
    end
  end

  assign res_data = {2'b00, hum_nxt, temp_nxt, status_nxt, done,
                     phase_nxt != PH_IDLE, drv_lvl, drv_en};

  // Update reader state on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      tick_r   <= '0;
      bidx_r   <= '0;
      frame_r  <= '0;
      status_r <= ST_OK;
      temp_r   <= '0;
      hum_r    <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      tick_r   <= tick_nxt;
      bidx_r   <= bidx_nxt;
      frame_r  <= frame_nxt;
      status_r <= status_nxt;
      temp_r   <= temp_nxt;
      hum_r    <= hum_nxt;
    end
  end

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_data;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A driving tick always reports a reading in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[2])
    else $error("drive without busy");

  // A finished reading is no longer busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done while busy");

  // Bit count never passes the frame length
  assert property (@(posedge clk) disable iff (!rst_n)
    bidx_r <= BIDX_BITS'(FRAME_LEN))
    else $error("bit index overflow");

  // A waited phase never outlasts the timeout
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_RESP_LOW || phase_r == PH_RESP_HIGH ||
     phase_r == PH_BIT_LOW || phase_r == PH_BIT_HIGH)
      |-> tick_r <= cnt_t'(cfg.timeout_ticks))
    else $error("timer beyond timeout");

  // Every accepted tick yields a result next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_tvalid)
    else $error("result missing");

endmodule

`default_nettype wire
